// ===== hw/rtl/turning_point_extractor_deadband_defines.svh =====
// Assertion macros shared by the turning-point extractor.
// Each check is sampled on the rising edge of clk and is switched off while rst_n is low.
`ifndef TURNING_POINT_EXTRACTOR_DEADBAND_DEFINES_SVH
`define TURNING_POINT_EXTRACTOR_DEADBAND_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define TPED_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("turning point extractor: same-cycle check failed");

// Next-cycle implication.
`define TPED_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("turning point extractor: next-cycle check failed");

`else

`define TPED_ASSERT_NOW(label, ante, cons)
`define TPED_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ===== hw/rtl/tped_pkg.sv =====
package tped_pkg;

  // Widths fixed by the item fields.
  localparam int unsigned AMP_BITS   = 12;
  localparam int unsigned DT_BITS    = 16;
  localparam int unsigned CAP_BITS   = 16;
  localparam int unsigned CFG_BITS   = 16;
  localparam int unsigned COUNT_BITS = 16;

  // Default width of the sample tick.
  localparam int unsigned TIME_BITS_DEFAULT = 16;

  // Offset that moves a signed sample into the unsigned amplitude range.
  localparam logic [AMP_BITS-1:0] AMP_OFFSET = 12'd2047;

  // Register reset values.
  localparam logic [AMP_BITS-1:0] DEAD_BAND_RESET = 12'd30;
  localparam logic [CAP_BITS-1:0] CAPACITY_RESET  = 16'd1024;

  // Reserved pairs taken off the capacity.
  localparam logic [CAP_BITS-1:0] RESERVED_PAIRS = 16'd2;

  // Configuration register indexes.
  typedef enum logic {
    REG_DEAD_BAND      = 1'b0,
    REG_POINT_CAPACITY = 1'b1
  } reg_idx_t;

  // Input commands.
  typedef enum logic [1:0] {
    CMD_START  = 2'd0,
    CMD_SAMPLE = 2'd1,
    CMD_END    = 2'd2
  } cmd_t;

  // Kinds of emitted point.
  typedef enum logic [1:0] {
    KIND_FIRST   = 2'd0,
    KIND_TURNING = 2'd1,
    KIND_LAST    = 2'd2
  } kind_t;

  // One input item.
  typedef struct packed {
    logic [1:0]                 cmd;
    logic signed [AMP_BITS-1:0] sample;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic [DT_BITS-1:0]  delta_time;
    logic [AMP_BITS-1:0] amplitude;
    logic [1:0]          point_kind;
    logic                buffer_full;
  } out_item_t;

endpackage

// ===== hw/rtl/turning_point_extractor_deadband.sv =====
// Turning-point extractor with dead band.
//
// Input channel (in_valid, in_stall, in_item): commands start capture, converter
// sample and end capture. Result channel (out_valid, out_stall, out_item): the
// first point, each peak or valley, and the last point of a capture, each with
// its offset amplitude and the ticks since the previous emitted point.
// Configuration (cfg_we, cfg_index, cfg_wdata): dead band and point capacity,
// written while no item is in flight.
//
// An accepted item is held in an input register; when the output register can
// take a result, the window update and point decision are made in one pass and
// any result is loaded into the output register, which offers it to the receiver.
// One item is taken every cycle unless a stalled result holds the output register.
// When the receiver stalls, the result waits in the output register and the
// input register still advances if the waiting result is taken in that cycle;
// otherwise in_stall rises until out_stall falls.
// Synchronous reset clears both valid flags and the capture state and restores
// the register defaults (dead band 30, capacity 1024).
`include "turning_point_extractor_deadband_defines.svh"

module turning_point_extractor_deadband #(
  parameter int unsigned TIME_BITS = tped_pkg::TIME_BITS_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  tped_pkg::in_item_t              in_item,
  output logic                            out_valid,
  input  logic                            out_stall,
  output tped_pkg::out_item_t             out_item,
  input  logic                            cfg_we,
  input  logic                            cfg_index,
  input  logic [tped_pkg::CFG_BITS-1:0]   cfg_wdata
);

  localparam int unsigned AB = tped_pkg::AMP_BITS;
  localparam int unsigned CB = tped_pkg::COUNT_BITS;

  // Configuration registers.
  logic [AB-1:0]                 dead_band_r;
  logic [tped_pkg::CAP_BITS-1:0] capacity_r;

  // Input register.
  logic               s1_valid_r;
  tped_pkg::in_item_t s1_item_r;

  // Output register.
  logic                out_valid_r;
  tped_pkg::out_item_t out_item_r;

  // Capture state.
  logic [AB-1:0]        win_amp_r  [3];
  logic [TIME_BITS-1:0] win_tick_r [3];
  logic [1:0]           fill_r;
  logic [TIME_BITS-1:0] tick_r;
  logic [TIME_BITS-1:0] prev_tick_r;
  logic [CB-1:0]        points_r;
  logic                 capturing_r;

  logic [AB-1:0]        win_amp_nxt  [3];
  logic [TIME_BITS-1:0] win_tick_nxt [3];
  logic [1:0]           fill_nxt;
  logic [TIME_BITS-1:0] tick_nxt;
  logic [TIME_BITS-1:0] prev_tick_nxt;
  logic [CB-1:0]        points_nxt;
  logic                 capturing_nxt;

  logic                res_valid;
  tped_pkg::out_item_t res_item;
  logic                s1_go;
  logic                step;

  // Handshake: the input register moves when the output register can take a result.
  assign s1_go     = !out_valid_r || !out_stall;
  assign step      = s1_valid_r && s1_go;
  assign in_stall  = s1_valid_r && !s1_go;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // Window update and point decision for the item in the input register.
  always_comb begin
    logic [CB-1:0]        limit;
    logic [AB-1:0]        amp_new;
    logic [1:0]           slot;
    logic                 first;
    logic [AB-1:0]        a0, a1, a2;
    logic [AB-1:0]        d01, d12;
    logic                 fall01, fall12;
    logic [TIME_BITS-1:0] dt;

    limit   = (capacity_r >= tped_pkg::RESERVED_PAIRS) ?
              (capacity_r - tped_pkg::RESERVED_PAIRS) : '0;
    amp_new = $unsigned(s1_item_r.sample) + tped_pkg::AMP_OFFSET;
    slot    = (fill_r == 2'd3) ? 2'd2 : fill_r;
    first   = (tick_r == '0) && (points_r == '0);
    a0      = '0;
    a1      = '0;
    a2      = '0;
    d01     = '0;
    d12     = '0;
    fall01  = 1'b0;
    fall12  = 1'b0;
    dt      = '0;

    for (int i = 0; i < 3; i++) begin
      win_amp_nxt[i]  = win_amp_r[i];
      win_tick_nxt[i] = win_tick_r[i];
    end
    fill_nxt      = fill_r;
    tick_nxt      = tick_r;
    prev_tick_nxt = prev_tick_r;
    points_nxt    = points_r;
    capturing_nxt = capturing_r;
    res_valid     = 1'b0;
    res_item      = '0;

    case (s1_item_r.cmd)
      tped_pkg::CMD_START: begin
        // A start always begins a fresh capture.
        for (int i = 0; i < 3; i++) begin
          win_amp_nxt[i]  = '0;
          win_tick_nxt[i] = '0;
        end
        fill_nxt      = '0;
        tick_nxt      = '0;
        prev_tick_nxt = '0;
        points_nxt    = '0;
        capturing_nxt = 1'b1;
      end
      tped_pkg::CMD_END: begin
        // The last point is window slot 2 as it stands.
        if (capturing_r) begin
          dt                   = win_tick_r[2] - prev_tick_r;
          res_valid            = 1'b1;
          res_item.delta_time  = tped_pkg::DT_BITS'(dt);
          res_item.amplitude   = win_amp_r[2];
          res_item.point_kind  = tped_pkg::KIND_LAST;
          res_item.buffer_full = (points_r >= limit);
          points_nxt           = points_r + 1'b1;
          capturing_nxt        = 1'b0;
        end
      end
      tped_pkg::CMD_SAMPLE: begin
        if (capturing_r && (points_r < limit)) begin
          win_amp_nxt[slot]  = amp_new;
          win_tick_nxt[slot] = tick_r;
          fill_nxt           = slot + 2'd1;
          tick_nxt           = tick_r + 1'b1;

          if (first) begin
            // The first sample of a capture is emitted straight away.
            points_nxt           = points_r + 1'b1;
            res_valid            = 1'b1;
            res_item.delta_time  = '0;
            res_item.amplitude   = win_amp_nxt[0];
            res_item.point_kind  = tped_pkg::KIND_FIRST;
            res_item.buffer_full = (points_nxt >= limit);
          end else if (fill_nxt == 2'd3) begin
            a0     = win_amp_nxt[0];
            a1     = win_amp_nxt[1];
            a2     = win_amp_nxt[2];
            d01    = (a0 >= a1) ? (a0 - a1) : (a1 - a0);
            d12    = (a1 >= a2) ? (a1 - a2) : (a2 - a1);
            fall01 = {1'b0, a0} > ({1'b0, a1} + {1'b0, dead_band_r});
            fall12 = {1'b0, a1} > ({1'b0, a2} + {1'b0, dead_band_r});
            if (d01 < dead_band_r) begin
              // First neighbour too close: drop it by sliding.
              win_amp_nxt[0]  = win_amp_nxt[1];
              win_tick_nxt[0] = win_tick_nxt[1];
              win_amp_nxt[1]  = win_amp_nxt[2];
              win_tick_nxt[1] = win_tick_nxt[2];
              fill_nxt        = 2'd2;
            end else if (d12 < dead_band_r) begin
              // Last neighbour too close: drop the newest point.
              fill_nxt = 2'd2;
            end else if (fall01 != fall12) begin
              // Slopes disagree: the middle point is a peak or a valley.
              dt                   = win_tick_nxt[1] - prev_tick_r;
              prev_tick_nxt        = win_tick_nxt[1];
              points_nxt           = points_r + 1'b1;
              res_valid            = 1'b1;
              res_item.delta_time  = tped_pkg::DT_BITS'(dt);
              res_item.amplitude   = a1;
              res_item.point_kind  = tped_pkg::KIND_TURNING;
              res_item.buffer_full = (points_nxt >= limit);
              win_amp_nxt[0]       = win_amp_nxt[2];
              win_tick_nxt[0]      = win_tick_nxt[2];
              fill_nxt             = 2'd1;
            end else begin
              // No turning point: slide by one.
              win_amp_nxt[0]  = win_amp_nxt[1];
              win_tick_nxt[0] = win_tick_nxt[1];
              win_amp_nxt[1]  = win_amp_nxt[2];
              win_tick_nxt[1] = win_tick_nxt[2];
              fill_nxt        = 2'd2;
            end
          end
        end
      end
      default: begin
        // Unknown command: the item is dropped.
      end
    endcase
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dead_band_r <= tped_pkg::DEAD_BAND_RESET;
      capacity_r  <= tped_pkg::CAPACITY_RESET;
    end else if (cfg_we) begin
      if (cfg_index == tped_pkg::REG_DEAD_BAND) begin
        dead_band_r <= cfg_wdata[AB-1:0];
      end else begin
        capacity_r <= cfg_wdata[tped_pkg::CAP_BITS-1:0];
      end
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_item_r <= in_item;
    end
  end

  // Capture state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        win_amp_r[i]  <= '0;
        win_tick_r[i] <= '0;
      end
      fill_r      <= '0;
      tick_r      <= '0;
      prev_tick_r <= '0;
      points_r    <= '0;
      capturing_r <= 1'b0;
    end else if (step) begin
      for (int i = 0; i < 3; i++) begin
        win_amp_r[i]  <= win_amp_nxt[i];
        win_tick_r[i] <= win_tick_nxt[i];
      end
      fill_r      <= fill_nxt;
      tick_r      <= tick_nxt;
      prev_tick_r <= prev_tick_nxt;
      points_r    <= points_nxt;
      capturing_r <= capturing_nxt;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step && res_valid) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res_valid) begin
      out_item_r <= res_item;
    end
  end

  // Checks on the window, the restart path and the stall path.
  `TPED_ASSERT_NOW(a_fill_settled, 1'b1, fill_r != 2'd3)
  `TPED_ASSERT_NEXT(a_start_clears, step && (s1_item_r.cmd == tped_pkg::CMD_START),
                    (points_r == '0) && capturing_r && (fill_r == '0))
  `TPED_ASSERT_NOW(a_stall_cause, in_stall, out_valid_r && out_stall)
  `TPED_ASSERT_NOW(a_result_source, $rose(out_valid_r), $past(s1_valid_r))

endmodule

// ===== dv/turning_point_extractor_deadband_tb.sv =====
module turning_point_extractor_deadband_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Command code that the block must ignore.
  localparam logic [1:0] CMD_UNKNOWN = 2'd3;

  // Cycles to let an item with no result clear the pipeline before a register write.
  localparam int unsigned DRAIN_CYCLES   = 6;
  // Cycles with no item moving on either side before the run is abandoned.
  localparam int unsigned WATCHDOG_LIMIT = 3000;
  // Length of the long receiver hold-off that fills the block.
  localparam int unsigned HOLD_CYCLES    = 150;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  tped_pkg::in_item_t            in_item = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  tped_pkg::out_item_t           out_item;
  logic                          cfg_we = 1'b0;
  logic                          cfg_index = tped_pkg::REG_DEAD_BAND;
  logic [tped_pkg::CFG_BITS-1:0] cfg_wdata = '0;

  turning_point_extractor_deadband DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #4 clk = ~clk;

  // Shadow copy of the capture state and the registers.
  logic [tped_pkg::AMP_BITS-1:0]   tp_amp [3];
  logic [tped_pkg::DT_BITS-1:0]    tp_tick [3];
  logic [1:0]                      tp_fill;
  logic [tped_pkg::DT_BITS-1:0]    tp_ticks;
  logic [tped_pkg::DT_BITS-1:0]    tp_last_emit;
  logic [tped_pkg::COUNT_BITS-1:0] tp_emitted;
  bit                              tp_capturing;
  logic [tped_pkg::AMP_BITS-1:0]   band_setting;
  logic [tped_pkg::CAP_BITS-1:0]   capacity_setting;

  tped_pkg::in_item_t  pending_items [$];
  tped_pkg::out_item_t expected_points [$];
  int unsigned items_queued = 0;
  int unsigned items_taken = 0;
  int unsigned points_checked = 0;
  int unsigned turning_seen = 0;
  int unsigned full_seen = 0;
  int unsigned settings_used = 1;
  int unsigned mismatch_count = 0;

  int          wave_level = 0;
  bit          wave_rise = 1'b1;

  function automatic void tracker_clear();
    for (int i = 0; i < 3; i++) begin
      tp_amp[i]  = '0;
      tp_tick[i] = '0;
    end
    tp_fill      = '0;
    tp_ticks     = '0;
    tp_last_emit = '0;
    tp_emitted   = '0;
  endfunction

  function automatic void window_slide();
    tp_amp[0]  = tp_amp[1];
    tp_tick[0] = tp_tick[1];
    tp_amp[1]  = tp_amp[2];
    tp_tick[1] = tp_tick[2];
    tp_fill    = 2'd2;
  endfunction

  // Applies one accepted item to the shadow state; returns 1 when it yields a point.
  function automatic bit predict_point(input tped_pkg::in_item_t it,
                                       output tped_pkg::out_item_t pt);
    logic [tped_pkg::CAP_BITS-1:0] lim;
    logic [tped_pkg::AMP_BITS-1:0] amp;
    logic [1:0]                    slot;
    int                            a0, a1, a2, band;
    bit                            first, fall01, fall12;
    pt   = '0;
    lim  = (capacity_setting >= tped_pkg::RESERVED_PAIRS) ?
           capacity_setting - tped_pkg::RESERVED_PAIRS : '0;
    band = band_setting;
    case (it.cmd)
      tped_pkg::CMD_START: begin
        tracker_clear();
        tp_capturing = 1'b1;
        return 1'b0;
      end
      tped_pkg::CMD_END: begin
        if (!tp_capturing) return 1'b0;
        pt.delta_time  = tp_tick[2] - tp_last_emit;
        pt.amplitude   = tp_amp[2];
        pt.point_kind  = tped_pkg::KIND_LAST;
        pt.buffer_full = (tp_emitted >= lim);
        tp_emitted++;
        tp_capturing = 1'b0;
        return 1'b1;
      end
      tped_pkg::CMD_SAMPLE: begin
        if (!tp_capturing || tp_emitted >= lim) return 1'b0;
        amp   = $unsigned(it.sample) + tped_pkg::AMP_OFFSET;
        slot  = (tp_fill > 2'd2) ? 2'd2 : tp_fill;
        first = (tp_ticks == '0 && tp_emitted == '0);
        tp_amp[slot]  = amp;
        tp_tick[slot] = tp_ticks;
        tp_fill       = slot + 2'd1;
        tp_ticks++;
        // The opening sample of a capture is reported at once.
        if (first) begin
          tp_emitted++;
          pt.amplitude   = tp_amp[0];
          pt.point_kind  = tped_pkg::KIND_FIRST;
          pt.buffer_full = (tp_emitted >= lim);
          return 1'b1;
        end
        if (tp_fill == 2'd3) begin
          a0 = tp_amp[0];
          a1 = tp_amp[1];
          a2 = tp_amp[2];
          if ((a0 > a1 ? a0 - a1 : a1 - a0) < band) begin
            window_slide();
          end else if ((a1 > a2 ? a1 - a2 : a2 - a1) < band) begin
            tp_fill = 2'd2;
          end else begin
            fall01 = (a0 > a1 + band);
            fall12 = (a1 > a2 + band);
            // Slopes disagree: the middle point is a peak or a valley.
            if (fall01 != fall12) begin
              pt.delta_time  = tp_tick[1] - tp_last_emit;
              tp_last_emit   = tp_tick[1];
              tp_emitted++;
              pt.amplitude   = tp_amp[1];
              pt.point_kind  = tped_pkg::KIND_TURNING;
              pt.buffer_full = (tp_emitted >= lim);
              tp_amp[0]      = tp_amp[2];
              tp_tick[0]     = tp_tick[2];
              tp_fill        = 2'd1;
              return 1'b1;
            end
            window_slide();
          end
        end
        return 1'b0;
      end
      default: return 1'b0;
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic check_point(input tped_pkg::out_item_t got);
    tped_pkg::out_item_t want;
    if (expected_points.size() == 0) begin
      report_mismatch($sformatf("point with nothing expected: dt=%0d amp=%0d kind=%0d full=%0d",
                                got.delta_time, got.amplitude, got.point_kind,
                                got.buffer_full));
      return;
    end
    want = expected_points.pop_front();
    points_checked++;
    if (want.point_kind == tped_pkg::KIND_TURNING) turning_seen++;
    if (want.buffer_full) full_seen++;
    if (got.delta_time !== want.delta_time)
      report_mismatch($sformatf("point %0d delta_time got %0d want %0d",
                                points_checked, got.delta_time, want.delta_time));
    if (got.amplitude !== want.amplitude)
      report_mismatch($sformatf("point %0d amplitude got %0d want %0d",
                                points_checked, got.amplitude, want.amplitude));
    if (got.point_kind !== want.point_kind)
      report_mismatch($sformatf("point %0d point_kind got %0d want %0d",
                                points_checked, got.point_kind, want.point_kind));
    if (got.buffer_full !== want.buffer_full)
      report_mismatch($sformatf("point %0d buffer_full got %0d want %0d",
                                points_checked, got.buffer_full, want.buffer_full));
  endtask

  // Mostly back-to-back, sometimes a short pause, now and then a long one.
  function automatic int unsigned idle_len(input bit quiet);
    int unsigned r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Sender: offers queued items, holds a stalled item steady.
  int unsigned         send_gap = 0;
  bit                  send_quiet = 1'b0;
  tped_pkg::out_item_t next_point;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        if (predict_point(in_item, next_point)) expected_points.push_back(next_point);
        items_taken++;
      end
      if (in_valid && in_stall) begin
        // Item still waiting; leave it in place.
      end else if (send_gap > 0 || pending_items.size() == 0) begin
        if (send_gap > 0) send_gap--;
        in_valid <= 1'b0;
      end else begin
        in_item  <= pending_items.pop_front();
        in_valid <= 1'b1;
        send_gap = idle_len(send_quiet);
        if ($urandom_range(0, 49) == 0) send_quiet = !send_quiet;
      end
    end
  end

  // Receiver: checks each point taken, stalls at random and now and then for a long stretch.
  int unsigned recv_stall = 0;
  int unsigned recv_hold = 0;
  bit          recv_quiet = 1'b0;
  int unsigned points_taken = 0;

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        check_point(out_item);
        points_taken++;
        if (points_taken % 400 == 50) recv_hold = HOLD_CYCLES;
      end
      if (recv_hold > 0) begin
        recv_hold--;
        out_stall <= 1'b1;
      end else if (recv_stall > 0) begin
        recv_stall--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        if ($urandom_range(0, 3) == 0) recv_stall = idle_len(recv_quiet);
        if ($urandom_range(0, 59) == 0) recv_quiet = !recv_quiet;
      end
    end
  end

  // Watchdog on cycles in which nothing moves.
  int unsigned still_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      still_cycles = 0;
    end else begin
      still_cycles++;
      if (still_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog: nothing moved for %0d cycles, %0d points still expected",
                 still_cycles, expected_points.size());
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  task automatic queue_item(input logic [1:0] c, input int s);
    tped_pkg::in_item_t it;
    it.cmd    = c;
    it.sample = s[tped_pkg::AMP_BITS-1:0];
    pending_items.push_back(it);
    items_queued++;
  endtask

  // One capture of a wandering waveform, with steps scaled to the dead band.
  task automatic queue_capture(input int unsigned len, input bit close);
    int stepv;
    queue_item(tped_pkg::CMD_START, $urandom);
    for (int unsigned i = 0; i < len; i++) begin
      if ($urandom_range(0, 3) == 0) wave_rise = !wave_rise;
      if ($urandom_range(0, 31) == 0) begin
        wave_level = int'($urandom_range(0, 4095)) - 2048;
      end else begin
        stepv = $urandom_range(0, band_setting + band_setting / 2 + 50);
        wave_level += wave_rise ? stepv : -stepv;
      end
      if (wave_level > 2047) wave_level = 2047;
      if (wave_level < -2048) wave_level = -2048;
      queue_item(tped_pkg::CMD_SAMPLE, wave_level);
    end
    if (close) queue_item(tped_pkg::CMD_END, $urandom);
  endtask

  // Mostly complete captures, some cut short or left open, a little stray traffic.
  task automatic queue_random_traffic(input int unsigned target);
    int unsigned made, r, len;
    made = 0;
    while (made < target) begin
      r = $urandom_range(0, 99);
      if (r < 6) begin
        queue_item(2'($urandom_range(0, 3)), $urandom);
      end else begin
        if (r < 14) len = $urandom_range(0, 2);
        else if (r < 97) len = $urandom_range(3, 30);
        else len = $urandom_range(31, 150);
        queue_capture(len, $urandom_range(0, 9) != 0);
        made += len + 2;
      end
    end
  endtask

  task automatic wait_idle();
    while (items_taken != items_queued || expected_points.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input tped_pkg::reg_idx_t idx,
                           input logic [tped_pkg::CFG_BITS-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    if (idx == tped_pkg::REG_DEAD_BAND) band_setting = value[tped_pkg::AMP_BITS-1:0];
    else capacity_setting = value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_phase(input logic [tped_pkg::AMP_BITS-1:0] band,
                           input logic [tped_pkg::CAP_BITS-1:0] cap,
                           input int unsigned target);
    wait_idle();
    write_reg(tped_pkg::REG_DEAD_BAND, band);
    write_reg(tped_pkg::REG_POINT_CAPACITY, cap);
    settings_used++;
    queue_random_traffic(target);
  endtask

  initial begin
    tracker_clear();
    tp_capturing     = 1'b0;
    band_setting     = tped_pkg::DEAD_BAND_RESET;
    capacity_setting = tped_pkg::CAPACITY_RESET;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed items under the reset settings.
    queue_item(CMD_UNKNOWN, 0);                 // unknown command while idle
    queue_item(tped_pkg::CMD_SAMPLE, 100);      // sample outside a capture
    queue_item(tped_pkg::CMD_END, 0);           // end outside a capture
    queue_item(tped_pkg::CMD_START, 0);
    queue_item(tped_pkg::CMD_END, 0);           // end straight after start: empty last slot
    queue_item(tped_pkg::CMD_START, 0);
    queue_item(tped_pkg::CMD_SAMPLE, -2048);    // offset wraps to full scale
    queue_item(tped_pkg::CMD_SAMPLE, 0);
    queue_item(tped_pkg::CMD_SAMPLE, 2047);
    queue_item(tped_pkg::CMD_SAMPLE, -2048);
    queue_item(tped_pkg::CMD_SAMPLE, 0);
    queue_item(tped_pkg::CMD_SAMPLE, 10);       // within the dead band of its neighbour
    queue_item(CMD_UNKNOWN, -1);                // unknown command mid-capture
    queue_item(tped_pkg::CMD_SAMPLE, 1000);
    queue_item(tped_pkg::CMD_START, 0);         // restart while capturing
    queue_item(tped_pkg::CMD_SAMPLE, 5);
    queue_item(tped_pkg::CMD_SAMPLE, 500);
    queue_item(tped_pkg::CMD_SAMPLE, -500);
    queue_item(tped_pkg::CMD_SAMPLE, 600);
    queue_item(tped_pkg::CMD_END, 0);
    queue_item(tped_pkg::CMD_END, -1);          // second end is ignored
    queue_random_traffic(250);

    // Register settings, extremes first.
    run_phase('0, 16'd3, 150);
    run_phase(12'd4095, 16'd65535, 150);
    run_phase(12'($urandom_range(1, 60)), 16'($urandom_range(4, 12)), 300);
    run_phase(12'($urandom_range(0, 150)), tped_pkg::CAPACITY_RESET, 500);
    run_phase(12'($urandom_range(0, 400)), 16'($urandom_range(3, 65535)), 400);

    wait_idle();
    if (expected_points.size() != 0)
      report_mismatch($sformatf("%0d points never arrived", expected_points.size()));
    $display("Summary: %0d items over %0d register settings, %0d points checked.",
             items_taken, settings_used, points_checked);
    $display("Summary: %0d turning points, %0d points with the buffer full, %0d mismatches.",
             turning_seen, full_seen, mismatch_count);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/tped_pkg.sv
hw/rtl/turning_point_extractor_deadband.sv
dv/turning_point_extractor_deadband_tb.sv
